### design/lhil_pkg.sv
// Shared constants and character helpers for the listing hex image loader.
package lhil_pkg;

    localparam int IMAGE_ADDR_BITS_DEF = 18;
    localparam int BASE_ADDR_BITS      = 16;
    localparam int BANK_SHIFT          = 16;

    localparam logic [BASE_ADDR_BITS-1:0] BASE_ADDR_RESET = 16'h8000;

    localparam logic [7:0] CH_END    = 8'h7C;  // '|'
    localparam logic [7:0] CH_COLON  = 8'h3A;  // ':'
    localparam logic [7:0] CH_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE   = 8'h39;  // '9'
    localparam logic [7:0] CH_UPPER_A = 8'h41; // 'A'
    localparam logic [7:0] CH_UPPER_F = 8'h46; // 'F'
    localparam logic [7:0] CH_ALPHA_OFS = 8'd55; // 'A' - 10

    localparam logic [2:0] ADDR_DIGITS = 3'd4;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // Codes from 'A' up map to code - 55, codes from '0' up to code - 48, anything lower stays as is.
    function automatic logic [7:0] digit_value(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_UPPER_A)
            v = c - CH_ALPHA_OFS;
        else if (c >= CH_ZERO)
            v = c - CH_ZERO;
        else
            v = c;
        return v;
    endfunction

    function automatic logic is_hex_char(input logic [7:0] c);
        return ((c >= CH_ZERO) && (c <= CH_NINE)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
    endfunction

endpackage

### design/lhil_channels.sv
// Valid/ready channel interfaces: listing characters in, image writes out.
interface lhil_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink   (input valid, input char_in, output ready);
endinterface

interface lhil_wr_if #(
    parameter int ADDR_BITS = lhil_pkg::IMAGE_ADDR_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [ADDR_BITS-1:0] write_address;
    logic [7:0]           write_data;

    modport source (output valid, output kind, output write_address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input write_address, input write_data,
                    output ready);
endinterface

### design/lhil_in_stage.sv
// Input register: holds one listing character until the parser takes it.
module lhil_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_char,
    input  logic       take,
    output logic       item_valid,
    output logic [7:0] item_char
);
    import lhil_pkg::*;

    logic       valid_reg;
    logic [7:0] char_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_char  = char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= in_char;
        end
    end

endmodule

### design/lhil_parser.sv
// Parser: mode, address, nibble state; one char per cycle unless stalled.
module lhil_parser #(
    parameter int ADDR_BITS = lhil_pkg::IMAGE_ADDR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [lhil_pkg::BASE_ADDR_BITS-1:0] base_address,
    input  logic                                item_valid,
    input  logic [7:0]                          item_char,
    input  logic                                out_free,
    output logic                                take,
    output logic                                res_valid,
    output logic                                res_kind,
    output logic [ADDR_BITS-1:0]                res_addr,
    output logic [7:0]                          res_data
);
    import lhil_pkg::*;

    localparam int BANK_OFS_BITS = 8 + BANK_SHIFT;

    logic                 data_mode_reg,   data_mode_next;
    logic [2:0]           digits_left_reg, digits_left_next;
    logic [ADDR_BITS-1:0] accum_reg,       accum_next;
    logic                 pending_reg,     pending_next;
    logic [7:0]           high_nib_reg,    high_nib_next;
    logic [7:0]           prev_char_reg,   prev_char_next;
    logic [ADDR_BITS-1:0] location_reg,    location_next;
    logic [7:0]           bank_reg,        bank_next;
    logic                 finished_reg,    finished_next;

    logic [7:0]           digit;
    logic                 produces;
    logic [ADDR_BITS-1:0] bank_ofs;

    assign digit    = digit_value(item_char);
    assign bank_ofs = ADDR_BITS'({bank_reg, {BANK_SHIFT{1'b0}}} & {BANK_OFS_BITS{1'b1}});

    always_comb
    begin
        data_mode_next   = data_mode_reg;
        digits_left_next = digits_left_reg;
        accum_next       = accum_reg;
        pending_next     = pending_reg;
        high_nib_next    = high_nib_reg;
        prev_char_next   = prev_char_reg;
        location_next    = location_reg;
        bank_next        = bank_reg;
        finished_next    = finished_reg;
        produces         = 1'b0;
        res_kind         = KIND_WRITE;
        res_addr         = '0;
        res_data         = '0;

        if (!finished_reg)
        begin
            priority if (digits_left_reg != 3'd0)
            begin
                // Load address digit: taken whatever the character is.
                if (digits_left_reg == ADDR_DIGITS)
                    prev_char_next = digit;
                accum_next       = {accum_reg[ADDR_BITS-5:0], 4'b0000} + ADDR_BITS'(digit);
                digits_left_next = digits_left_reg - 3'd1;
                if (digits_left_reg == 3'd1)
                    location_next = accum_next - ADDR_BITS'(base_address);
            end
            else if (pending_reg)
            begin
                // Second nibble completes the pair: emit and advance.
                produces      = 1'b1;
                res_addr      = location_reg + bank_ofs;
                res_data      = {high_nib_reg[3:0], 4'b0000} + digit;
                pending_next  = 1'b0;
                location_next = location_reg + ADDR_BITS'(1);
            end
            else if (item_char == CH_COLON)
            begin
                bank_next = prev_char_reg - CH_ZERO;
                if (!data_mode_reg)
                begin
                    data_mode_next   = 1'b1;
                    digits_left_next = ADDR_DIGITS;
                    accum_next       = '0;
                end
                else
                begin
                    data_mode_next = 1'b0;
                    prev_char_next = item_char;
                end
            end
            else if (data_mode_reg && is_hex_char(item_char))
            begin
                high_nib_next  = digit;
                pending_next   = 1'b1;
                prev_char_next = digit;
            end
            else
            begin
                prev_char_next = item_char;
                if (item_char == CH_END)
                begin
                    finished_next = 1'b1;
                    produces      = 1'b1;
                    res_kind      = KIND_END;
                end
            end
        end
    end

    // Items with no result never wait on the output side.
    assign take      = item_valid && (!produces || out_free);
    assign res_valid = take && produces;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_mode_reg   <= 1'b0;
            digits_left_reg <= 3'd0;
            accum_reg       <= '0;
            pending_reg     <= 1'b0;
            high_nib_reg    <= 8'd0;
            prev_char_reg   <= 8'd0;
            location_reg    <= '0;
            bank_reg        <= 8'd0;
            finished_reg    <= 1'b0;
        end
        else if (take)
        begin
            data_mode_reg   <= data_mode_next;
            digits_left_reg <= digits_left_next;
            accum_reg       <= accum_next;
            pending_reg     <= pending_next;
            high_nib_reg    <= high_nib_next;
            prev_char_reg   <= prev_char_next;
            location_reg    <= location_next;
            bank_reg        <= bank_next;
            finished_reg    <= finished_next;
        end
    end

`ifndef SYNTHESIS
    a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> !res_valid)
        else $error("result produced after end marker");

    a_silent_in_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (digits_left_reg != 3'd0) |-> !res_valid)
        else $error("result produced while reading load address");

    a_end_latches: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_kind == KIND_END) |=> finished_reg)
        else $error("end marker reported without finishing");

    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (take && !finished_reg && digits_left_reg != 3'd0)
            |=> (digits_left_reg == $past(digits_left_reg) - 3'd1))
        else $error("address digit count did not step down");

    a_pair_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_kind == KIND_WRITE) |=> !pending_reg)
        else $error("nibble pair still pending after byte write");
`endif

endmodule

### design/lhil_out_stage.sv
// Result register: holds one write or end beat until the sink takes it.
module lhil_out_stage #(
    parameter int ADDR_BITS = lhil_pkg::IMAGE_ADDR_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  logic                 load_kind,
    input  logic [ADDR_BITS-1:0] load_addr,
    input  logic [7:0]           load_data,
    output logic                 out_free,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_kind,
    output logic [ADDR_BITS-1:0] out_addr,
    output logic [7:0]           out_data
);
    import lhil_pkg::*;

    logic                 valid_reg;
    logic                 kind_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [7:0]           data_reg;

    assign out_free  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_addr  = addr_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= load_kind;
            addr_reg <= load_addr;
            data_reg <= load_data;
        end
    end

endmodule

### design/listing_hex_image_loader_core.sv
// Top level of the listing hex image loader: register stages and base address.
//
//   channel    dir  carries                                 accepted when
//   char_chan  in   char_in, one listing character          valid && ready
//   wr_chan    out  kind, write_address, write_data         valid && ready
//   cfg        in   cfg_wdata -> base_address               cfg_we
//
// One character per cycle is sustained unless a beat waits on a full result
// register; a character is held in the input register and its beat, if any,
// is loaded into the result register when the parser takes it. The parser state loop (mode, digit
// count, address, pending nibble) is updated once per accepted character.
// Reset clears all control state and sets base_address to 0x8000.
// A stall on wr_chan only holds characters that make a beat; others keep
// flowing past a full result register.
module listing_hex_image_loader_core #(
    parameter int IMAGE_ADDR_BITS = lhil_pkg::IMAGE_ADDR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lhil_pkg::BASE_ADDR_BITS-1:0] cfg_wdata,
    lhil_char_if.sink                           char_chan,
    lhil_wr_if.source                           wr_chan
);
    import lhil_pkg::*;

    logic [BASE_ADDR_BITS-1:0]  base_addr_reg;

    logic                       take;
    logic                       item_valid;
    logic [7:0]                 item_char;
    logic                       out_free;
    logic                       res_valid;
    logic                       res_kind;
    logic [IMAGE_ADDR_BITS-1:0] res_addr;
    logic [7:0]                 res_data;

    // Base address register: the user must write it only while idle; the block does not enforce it. No read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg <= BASE_ADDR_RESET;
        end
        else if (cfg_we)
        begin
            base_addr_reg <= cfg_wdata;
        end
    end

    // Capture one character per beat.
    lhil_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (char_chan.valid),
        .in_ready   (char_chan.ready),
        .in_char    (char_chan.char_in),
        .take       (take),
        .item_valid (item_valid),
        .item_char  (item_char)
    );

    // Decode the character against the parser state.
    lhil_parser #(
        .ADDR_BITS (IMAGE_ADDR_BITS)
    ) u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_address (base_addr_reg),
        .item_valid   (item_valid),
        .item_char    (item_char),
        .out_free     (out_free),
        .take         (take),
        .res_valid    (res_valid),
        .res_kind     (res_kind),
        .res_addr     (res_addr),
        .res_data     (res_data)
    );

    // Hold the result beat until the sink takes it.
    lhil_out_stage #(
        .ADDR_BITS (IMAGE_ADDR_BITS)
    ) u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_kind (res_kind),
        .load_addr (res_addr),
        .load_data (res_data),
        .out_free  (out_free),
        .out_valid (wr_chan.valid),
        .out_ready (wr_chan.ready),
        .out_kind  (wr_chan.kind),
        .out_addr  (wr_chan.write_address),
        .out_data  (wr_chan.write_data)
    );

endmodule

### tb/sv/image_write_checker.sv
`timescale 1ns / 100ps
// Checker for the listing hex image loader: predicts image writes and compares every beat.
module image_write_checker #(
    parameter int ADDR_BITS = lhil_pkg::IMAGE_ADDR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lhil_pkg::BASE_ADDR_BITS-1:0] cfg_wdata,
    lhil_char_if                                char_chan,
    lhil_wr_if                                  wr_chan,
    output int                                  fail_count,
    output int                                  outstanding
);

    import lhil_pkg::*;

    typedef struct packed {
        logic                 kind;
        logic [ADDR_BITS-1:0] address;
        logic [7:0]           data;
    } image_write_t;

    image_write_t expected_writes[$];

    // Parser state as the block should hold it.
    logic [BASE_ADDR_BITS-1:0] base;
    logic                      in_data;
    logic [2:0]                digits_left;
    logic [ADDR_BITS-1:0]      accum;
    logic [ADDR_BITS-1:0]      location;
    logic                      nibble_waiting;
    logic [7:0]                high_nib;
    logic [7:0]                prev_char;
    logic [7:0]                bank;
    logic                      stream_done;

    function automatic logic [7:0] char_digit(input logic [7:0] c);
        if (c >= CH_UPPER_A)
            return c - (CH_UPPER_A - 8'd10);
        if (c >= CH_ZERO)
            return c - CH_ZERO;
        return c;
    endfunction

    function automatic logic opens_pair(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE], [CH_UPPER_A:CH_UPPER_F]};
    endfunction

    task automatic note_mismatch(input string what, input longint want, input longint got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
    endtask

    task automatic parse_listing_char(input logic [7:0] c);
        logic [7:0]   d;
        image_write_t w;
        d = char_digit(c);
        if (stream_done) begin
            // drop everything after the end marker
        end else if (digits_left != 3'd0) begin
            if (digits_left == ADDR_DIGITS)
                prev_char = d;
            accum = (accum << 4) + ADDR_BITS'(d);
            digits_left--;
            if (digits_left == 3'd0)
                location = accum - ADDR_BITS'(base);
        end else if (nibble_waiting) begin
            w.kind    = KIND_WRITE;
            w.address = location + (ADDR_BITS'(bank) << BANK_SHIFT);
            w.data    = (high_nib << 4) + d;
            expected_writes.push_back(w);
            nibble_waiting = 1'b0;
            location = location + ADDR_BITS'(1);
        end else if (c == CH_COLON) begin
            bank = prev_char - CH_ZERO;
            if (!in_data) begin
                in_data     = 1'b1;
                digits_left = ADDR_DIGITS;
                accum       = '0;
            end else begin
                in_data   = 1'b0;
                prev_char = c;
            end
        end else if (in_data && opens_pair(c)) begin
            high_nib       = d;
            nibble_waiting = 1'b1;
            prev_char      = d;
        end else begin
            prev_char = c;
            if (c == CH_END) begin
                stream_done = 1'b1;
                w = '{kind: KIND_END, address: '0, data: '0};
                expected_writes.push_back(w);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        image_write_t w;
        if (!rst_n) begin
            base           = BASE_ADDR_RESET;
            in_data        = 1'b0;
            digits_left    = '0;
            accum          = '0;
            location       = '0;
            nibble_waiting = 1'b0;
            high_nib       = '0;
            prev_char      = '0;
            bank           = '0;
            stream_done    = 1'b0;
            fail_count     = 0;
            expected_writes.delete();
            outstanding <= 0;
        end else begin
            if (cfg_we)
                base = cfg_wdata;
            if (wr_chan.valid && wr_chan.ready) begin
                if (expected_writes.size() == 0) begin
                    note_mismatch("unexpected beat: kind", -1, wr_chan.kind);
                end else begin
                    w = expected_writes.pop_front();
                    if (wr_chan.kind !== w.kind)
                        note_mismatch("kind", w.kind, wr_chan.kind);
                    if (wr_chan.write_address !== w.address)
                        note_mismatch("write_address", w.address, wr_chan.write_address);
                    if (wr_chan.write_data !== w.data)
                        note_mismatch("write_data", w.data, wr_chan.write_data);
                end
            end
            if (char_chan.valid && char_chan.ready)
                parse_listing_char(char_chan.char_in);
            outstanding <= expected_writes.size();
        end
    end

endmodule

### tb/sv/listing_hex_image_loader_core_test.sv
`timescale 1ns / 100ps
// Test top for the listing hex image loader: stimulus, sink pacing, watchdog and verdict.
module listing_hex_image_loader_core_test;

    import lhil_pkg::*;

    localparam int          STALL_LIMIT  = 1000;  // cycles without any beat before giving up
    localparam int          DRAIN_CYCLES = 4;     // cycles to let the pipeline empty after the last predicted beat
    localparam logic [7:0]  CH_SPACE     = 8'h20;
    localparam logic [7:0]  CH_NEWLINE   = 8'h0A;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [BASE_ADDR_BITS-1:0] cfg_wdata;
    int                        fail_count;
    int                        outstanding;

    // Stimulus-side view of the parse: how many upcoming characters the block
    // takes unconditionally (address digits or the second nibble of a pair).
    // Only there may a '|' go out without ending the stream.
    int   bound_chars;
    logic tx_in_data;
    int   chars_sent;
    int   calm_left;
    int   ready_hold;
    int   idle_cycles;

    lhil_char_if char_chan();
    lhil_wr_if   wr_chan();

    listing_hex_image_loader_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .char_chan (char_chan),
        .wr_chan   (wr_chan)
    );

    image_write_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .char_chan   (char_chan),
        .wr_chan     (wr_chan),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Idle length before the next character: mostly back to back, some short
    // gaps, a few long ones, and now and then a run with no gaps at all.
    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        return (v < 10) ? CH_ZERO + 8'(v) : CH_UPPER_A + 8'(v - 10);
    endfunction

    // Free text for address mode: keep colons and end markers out of it.
    function automatic logic [7:0] text_char();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        return (c == CH_COLON || c == CH_END) ? CH_SPACE : c;
    endfunction

    // Present one character and hold it until its beat is taken. Ready is
    // sampled at the falling edge, so the accepting rising edge is known
    // without racing the block's own updates. Returns on the accepting edge.
    task automatic send_beat(input logic [7:0] c);
        int   gap;
        logic took;
        gap = pick_gap();
        if (gap > 0)
        begin
            char_chan.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_chan.valid   <= 1'b1;
        char_chan.char_in <= c;
        do
        begin
            @(negedge clk);
            took = char_chan.ready;
            @(posedge clk);
        end
        while (!took);
    endtask

    // Send a listing character, tracking the parse so a stray '|' never ends
    // the stream early; swap it for a space where it would stand alone.
    task automatic put(input logic [7:0] c);
        logic [7:0] b;
        b = (c == CH_END && bound_chars == 0) ? CH_SPACE : c;
        if (bound_chars != 0)
            bound_chars--;
        else if (b == CH_COLON)
        begin
            bound_chars = tx_in_data ? 0 : int'(ADDR_DIGITS);
            tx_in_data  = !tx_in_data;
        end
        else if (tx_in_data && ((b >= CH_ZERO && b <= CH_NINE) ||
                                (b >= CH_UPPER_A && b <= CH_UPPER_F)))
            bound_chars = 1;
        send_beat(b);
        chars_sent++;
    endtask

    // One listing line: text, bank digit, colon, four address digits, code
    // pairs, closing colon, trailing text, newline. Some digits and second
    // nibbles are arbitrary bytes, colons and end markers among them.
    task automatic send_line();
        if (tx_in_data)
            put(CH_COLON);
        repeat ($urandom_range(0, 3)) put(text_char());
        if ($urandom_range(0, 9) < 8)
            put(CH_ZERO + 8'($urandom_range(0, 3)));
        else
            put(text_char());
        put(CH_COLON);
        repeat (4) put(($urandom_range(0, 99) < 85) ? hex_char() : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 6))
        begin
            repeat ($urandom_range(0, 2)) put(CH_SPACE);
            put(hex_char());
            put(($urandom_range(0, 99) < 85) ? hex_char() : 8'($urandom_range(0, 255)));
        end
        put(CH_COLON);
        repeat ($urandom_range(0, 4)) put(text_char());
        put(CH_NEWLINE);
    endtask

    // Mostly well-formed lines, the rest raw byte noise.
    task automatic random_phase(input int count);
        int stop_at;
        stop_at = chars_sent + count;
        while (chars_sent < stop_at)
        begin
            if ($urandom_range(0, 99) < 80)
                send_line();
            else
                repeat ($urandom_range(1, 12)) put(8'($urandom_range(0, 255)));
        end
    endtask

    // Drop valid, wait until every predicted beat has arrived, then let the
    // pipeline empty of characters that make no beat. Ends on a rising edge.
    task automatic settle();
        char_chan.valid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_base(input logic [BASE_ADDR_BITS-1:0] value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Sink pacing: open stretches, short stalls and the odd long stall.
    always @(posedge clk)
    begin : sink_pace
        int r;
        if (!rst_n)
        begin
            wr_chan.ready <= 1'b0;
            ready_hold    <= 0;
        end
        else if (ready_hold > 0)
            ready_hold <= ready_hold - 1;
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
            begin
                wr_chan.ready <= 1'b1;
                ready_hold    <= $urandom_range(1, 30);
            end
            else if (r < 90)
            begin
                wr_chan.ready <= 1'b0;
                ready_hold    <= $urandom_range(1, 3);
            end
            else
            begin
                wr_chan.ready <= 1'b0;
                ready_hold    <= $urandom_range(8, 40);
            end
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((char_chan.valid && char_chan.ready) || (wr_chan.valid && wr_chan.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        logic [7:0] opening [$];
        bound_chars = 0;
        tx_in_data  = 1'b0;
        chars_sent  = 0;
        calm_left   = 0;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        char_chan.valid   <= 1'b0;
        char_chan.char_in <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening under the reset base:
        //  - a plain line at bank 0 whose address equals the base,
        //  - pairs with the extreme hex digits and a 0xFF second nibble,
        //  - a bank taken from a space, which wraps below '0',
        //  - address digits that are '|', ':' and 0xFF,
        //  - pairs completed by '|' and by ':',
        //  - characters ignored in address mode.
        opening = '{CH_ZERO, CH_COLON, "8", "0", "0", "0", "A", CH_NINE,
                    CH_UPPER_F, CH_UPPER_F, CH_ZERO, 8'hFF, CH_COLON,
                    8'h00, CH_SPACE, CH_COLON, CH_END, CH_COLON, 8'hFF, CH_ZERO,
                    CH_NINE, CH_END, CH_UPPER_F, CH_COLON, CH_COLON, "G"};
        foreach (opening[i])
            put(opening[i]);

        // Random phases across base settings, the extremes among them.
        random_phase(280);
        load_base('0);
        random_phase(280);
        load_base('1);
        random_phase(280);
        load_base(BASE_ADDR_BITS'($urandom_range(0, 65535)));
        random_phase(300);
        load_base(BASE_ADDR_BITS'($urandom_range(0, 65535)));
        random_phase(300);

        // Close the stream: a run of markers outlasts any digits or nibble
        // still owed, so one of them stands alone. Then check that what
        // follows is ignored.
        repeat (6) send_beat(CH_END);
        repeat (10) send_beat(8'($urandom_range(0, 255)));
        settle();

        if (fail_count == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
